// ----- hw/rtl/pdpt_pkg.sv -----
// Shared types and constants for the proximity dedup point table.
// Holds the field widths, register indexes, status codes and the
// command/status bundles between controller and datapath. No dependencies.
package pdpt_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned DEF_TABLE_DEPTH = 64;
  localparam int unsigned DEF_COORD_BITS  = 24;

  // Input item: three candidate and three observer coordinates
  localparam int unsigned NUM_IN_FIELDS = 6;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned RADIUS_W   = 23;

  localparam logic [CFG_IDX_W-1:0] CFG_DEDUP_RADIUS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_GATE_RADIUS  = CFG_IDX_W'(1);

  // Radii after reset: 100 m and 30 m in 1/256 m
  localparam logic [RADIUS_W-1:0] DEDUP_RADIUS_RST = RADIUS_W'(25600);
  localparam logic [RADIUS_W-1:0] GATE_RADIUS_RST  = RADIUS_W'(7680);

  // Result item fields
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned INDEX_OUT_W  = 6;
  localparam int unsigned COUNT_OUT_W  = 7;
  localparam int unsigned OUT_FIELDS_W = STATUS_W + INDEX_OUT_W + COUNT_OUT_W;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  localparam logic [STATUS_W-1:0] STATUS_BEYOND = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] STATUS_DUP    = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] STATUS_NEW    = STATUS_W'(2);
  localparam logic [STATUS_W-1:0] STATUS_FULL   = STATUS_W'(3);

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // capture candidate and observer from the input item
    logic issue;  // start one distance test
    logic gate;   // test is candidate vs observer (else vs stored entry)
    logic write;  // append candidate to the table
  } dp_cmd_t;

  // Datapath to controller status, one distance test result
  typedef struct packed {
    logic res_valid;
    logic res_gate;
    logic res_hit;
  } dp_sts_t;

endpackage

// ----- hw/rtl/pdpt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Used for the point table; no dependencies.
module pdpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/pdpt_datapath.sv -----
// Datapath: radius registers, point table RAM and a five-stage squared
// distance pipeline (read, select/diff, square, partial sum, sum and compare).
// Depends on pdpt_pkg and pdpt_ram.
module pdpt_datapath import pdpt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int unsigned COORD_BITS  = DEF_COORD_BITS,
  localparam int unsigned IDX_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dp_cmd_t                           cmd_i,
  input  logic [IDX_W-1:0]                  addr_i,
  input  logic [NUM_IN_FIELDS*COORD_BITS-1:0] in_fields_i,
  input  logic                              cfg_write_i,
  input  logic [CFG_IDX_W-1:0]              cfg_index_i,
  input  logic [CFG_DATA_W-1:0]             cfg_data_i,
  output dp_sts_t                           sts_o,
  output logic [IDX_W-1:0]                  res_index_o
);

  localparam int unsigned STAGES = 5;
  localparam int unsigned SQ_W   = 2 * COORD_BITS;
  localparam int unsigned DIST_W = SQ_W + 2;
  localparam int unsigned RSQ_W  = 2 * RADIUS_W;
  localparam int unsigned CMP_W  = (DIST_W > RSQ_W) ? DIST_W : RSQ_W;

  // Item operands
  logic [2:0][COORD_BITS-1:0] cand_q, obs_q, ram_rdata;

  // Radii and their squares
  logic [RADIUS_W-1:0] dedup_q, gate_q;
  logic [RSQ_W-1:0]    dedup_sq_q, gate_sq_q;

  // Pipeline control and data
  logic [STAGES-1:0]            v_q, g_q;
  logic [STAGES-1:0][IDX_W-1:0] i_q;
  logic [2:0][COORD_BITS-1:0]   abs_d, abs_q;
  logic [2:0][SQ_W-1:0]         sq_q;
  logic [SQ_W:0]                sum_xy_q;
  logic [SQ_W-1:0]              sq_z_q;
  logic [DIST_W-1:0]            dist_sum;
  logic                         hit_d, hit_q;

  // Radius registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dedup_q <= DEDUP_RADIUS_RST;
      gate_q  <= GATE_RADIUS_RST;
    end else if (cfg_write_i) begin
      if (cfg_index_i == CFG_DEDUP_RADIUS) begin
        dedup_q <= cfg_data_i[RADIUS_W-1:0];
      end else if (cfg_index_i == CFG_GATE_RADIUS) begin
        gate_q <= cfg_data_i[RADIUS_W-1:0];
      end
    end
  end

  // Point table, one row holds x, y, z
  pdpt_ram #(
    .WIDTH(3 * COORD_BITS),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (cmd_i.write),
    .waddr_i(addr_i),
    .wdata_i(cand_q),
    .raddr_i(addr_i),
    .rdata_o(ram_rdata)
  );

  // Select/diff: pick observer or stored point, absolute difference per axis
  always_comb begin
    logic [COORD_BITS-1:0] a_sel;
    logic [COORD_BITS:0]   d_ab, d_ba;
    for (int k = 0; k < 3; k++) begin
      a_sel    = g_q[0] ? obs_q[k] : ram_rdata[k];
      d_ab     = {a_sel[COORD_BITS-1], a_sel} - {cand_q[k][COORD_BITS-1], cand_q[k]};
      d_ba     = {cand_q[k][COORD_BITS-1], cand_q[k]} - {a_sel[COORD_BITS-1], a_sel};
      abs_d[k] = d_ab[COORD_BITS] ? d_ba[COORD_BITS-1:0] : d_ab[COORD_BITS-1:0];
    end
  end

  // Stage 5: final sum and radius test (gate accepts equality, dedup does not)
  assign dist_sum = DIST_W'(sum_xy_q) + DIST_W'(sq_z_q);
  assign hit_d    = g_q[3] ? (CMP_W'(dist_sum) <= CMP_W'(gate_sq_q))
                           : (CMP_W'(dist_sum) <  CMP_W'(dedup_sq_q));

  // Pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[STAGES-2:0], cmd_i.issue};
    end
  end

  // Pipeline payload and operand capture
  always_ff @(posedge clk_i) begin
    g_q <= {g_q[STAGES-2:0], cmd_i.gate};
    i_q <= {i_q[STAGES-2:0], addr_i};
    if (cmd_i.load) begin
      cand_q <= in_fields_i[3*COORD_BITS-1:0];
      obs_q  <= in_fields_i[6*COORD_BITS-1:3*COORD_BITS];
    end
    abs_q <= abs_d;
    for (int k = 0; k < 3; k++) begin
      sq_q[k] <= SQ_W'(abs_q[k]) * SQ_W'(abs_q[k]);
    end
    sum_xy_q   <= (SQ_W+1)'(sq_q[0]) + (SQ_W+1)'(sq_q[1]);
    sq_z_q     <= sq_q[2];
    hit_q      <= hit_d;
    dedup_sq_q <= RSQ_W'(dedup_q) * RSQ_W'(dedup_q);
    gate_sq_q  <= RSQ_W'(gate_q) * RSQ_W'(gate_q);
  end

  assign sts_o.res_valid = v_q[STAGES-1];
  assign sts_o.res_gate  = g_q[STAGES-1];
  assign sts_o.res_hit   = hit_q;
  assign res_index_o     = i_q[STAGES-1];

endmodule

// ----- hw/rtl/pdpt_ctrl.sv -----
// Controller: item sequencing (gate test, table scan, append), entry count
// and the result output register. Depends on pdpt_pkg.
module pdpt_ctrl import pdpt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
  localparam int unsigned IDX_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int unsigned CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [OUT_TDATA_W-1:0] out_data_o,
  output dp_cmd_t                cmd_o,
  output logic [IDX_W-1:0]       addr_o,
  input  dp_sts_t                sts_i,
  input  logic [IDX_W-1:0]       res_index_i
);

  typedef enum logic [4:0] {
    ST_IDLE      = 5'b00001,
    ST_WAIT_GATE = 5'b00010,
    ST_SCAN      = 5'b00100,
    ST_APPEND    = 5'b01000,
    ST_DONE      = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    issue_q, issue_d;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [IDX_W-1:0]    res_index_q, res_index_d;
  logic [IDX_W-1:0]    last_idx;
  logic                out_load;

  logic                   out_valid_q;
  logic [STATUS_W-1:0]    out_status_q;
  logic [INDEX_OUT_W-1:0] out_index_q;
  logic [COUNT_OUT_W-1:0] out_count_q;

  assign last_idx   = IDX_W'(count_q - CNT_W'(1));
  assign in_ready_o = (state_q == ST_IDLE);

  // Next-state and command logic
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    issue_d      = issue_q;
    res_status_d = res_status_q;
    res_index_d  = res_index_q;
    cmd_o        = '0;
    addr_o       = '0;
    out_load     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load  = 1'b1;
          cmd_o.issue = 1'b1;
          cmd_o.gate  = 1'b1;
          state_d     = ST_WAIT_GATE;
        end
      end
      ST_WAIT_GATE: begin
        // leftover scan results of the previous item are ignored here
        if (sts_i.res_valid && sts_i.res_gate) begin
          if (!sts_i.res_hit) begin
            res_status_d = STATUS_BEYOND;
            res_index_d  = '0;
            state_d      = ST_DONE;
          end else if (count_q == '0) begin
            state_d = ST_APPEND;
          end else begin
            issue_d = '0;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // one entry issued per cycle, results come back in order
        if (issue_q < count_q) begin
          cmd_o.issue = 1'b1;
          addr_o      = issue_q[IDX_W-1:0];
          issue_d     = issue_q + CNT_W'(1);
        end
        if (sts_i.res_valid && !sts_i.res_gate) begin
          if (sts_i.res_hit) begin
            res_status_d = STATUS_DUP;
            res_index_d  = res_index_i;
            state_d      = ST_DONE;
          end else if (res_index_i == last_idx) begin
            state_d = ST_APPEND;
          end
        end
      end
      ST_APPEND: begin
        if (count_q < CNT_W'(TABLE_DEPTH)) begin
          cmd_o.write  = 1'b1;
          addr_o       = count_q[IDX_W-1:0];
          count_d      = count_q + CNT_W'(1);
          res_status_d = STATUS_NEW;
          res_index_d  = count_q[IDX_W-1:0];
        end else begin
          res_status_d = STATUS_FULL;
          res_index_d  = '0;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      issue_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      issue_q <= issue_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_index_q  <= res_index_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_index_q  <= INDEX_OUT_W'(res_index_q);
      out_count_q  <= COUNT_OUT_W'(count_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {OUT_PAD_W'(0), out_count_q, out_index_q, out_status_q};

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_write_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.write |=> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("table write without count increment");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.issue && !cmd_o.gate) |-> (issue_q < count_q))
    else $error("scan read beyond stored entries");

  a_write_after_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.write |-> (state_q == ST_APPEND) && !cmd_o.issue)
    else $error("table write outside append step");
`endif

endmodule

// ----- hw/rtl/proximity_dedup_point_table_unit.sv -----
// Proximity dedup point table, top level. One item at a time; a new point
// follows a scan of all stored points, a duplicate of entry i a scan up to
// entry i; an empty table or an item beyond the gate skips the scan. The
// next item can be taken in the cycle after the result is registered; the
// table scan reads one RAM row per cycle. Reset clears count and control
// and restores the 100 m / 30 m radii; table contents are not cleared.
module proximity_dedup_point_table_unit import pdpt_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int unsigned COORD_BITS  = DEF_COORD_BITS,
  localparam int unsigned IN_FIELDS_W = NUM_IN_FIELDS * COORD_BITS,
  localparam int unsigned IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8,
  localparam int unsigned IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // tdata: cand_x, cand_y, cand_z, observer_x, observer_y, observer_z, pad
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // tdata: status, entry_index, point_count, pad
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // register write channel
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  dp_cmd_t          cmd;
  dp_sts_t          sts;
  logic [IDX_W-1:0] addr;
  logic [IDX_W-1:0] res_index;

  assign cfg_ready_o = 1'b1;

  pdpt_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata),
    .cmd_o      (cmd),
    .addr_o     (addr),
    .sts_i      (sts),
    .res_index_i(res_index)
  );

  pdpt_datapath #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .addr_i     (addr),
    .in_fields_i(s_axis_tdata[IN_FIELDS_W-1:0]),
    .cfg_write_i(cfg_valid_i & cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .sts_o      (sts),
    .res_index_o(res_index)
  );

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for proximity_dedup_point_table_unit.
// Streams candidate/observer points through the stream ports, predicts each verdict
// with a local model of the point table, and depends only on pdpt_pkg and the top level.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pdpt_pkg::*;

  localparam int unsigned DEPTH          = DEF_TABLE_DEPTH;
  localparam int unsigned COORD_BITS     = DEF_COORD_BITS;
  localparam int unsigned IN_TDATA_W     = ((NUM_IN_FIELDS * COORD_BITS + 7) / 8) * 8;
  localparam int unsigned PHASES         = 6;
  localparam int unsigned ITEMS_PER_PHASE = 210;
  localparam int unsigned DRAIN_CYCLES   = 80;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned HOLD_AFTER     = 300;
  localparam int unsigned HOLD_CYCLES    = 250;
  localparam int unsigned MAX_REPORTS    = 10;

  // Register indexes the block does not decode
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = CFG_IDX_W'(3);

  localparam logic [RADIUS_W-1:0] RADIUS_MAX = '1;
  localparam int COORD_MAX = (1 <<< (COORD_BITS - 1)) - 1;
  localparam int COORD_MIN = -(1 <<< (COORD_BITS - 1));

  typedef logic signed [COORD_BITS-1:0] coord_t;
  // Element 0 is x, in the low bits
  typedef logic signed [2:0][COORD_BITS-1:0] point3_t;

  // Input item as it sits in tdata: cand x,y,z in the low bits, then observer x,y,z
  typedef struct packed {
    point3_t obs;
    point3_t cand;
  } cand_item_t;

  // Result item as it sits in tdata, status in the low bits
  typedef struct packed {
    logic [OUT_PAD_W-1:0]   pad;
    logic [COUNT_OUT_W-1:0] point_count;
    logic [INDEX_OUT_W-1:0] entry_index;
    logic [STATUS_W-1:0]    status;
  } point_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;

  proximity_dedup_point_table_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow copy of the block: radii, stored points and count
  logic [RADIUS_W-1:0] dedup_lim = DEDUP_RADIUS_RST;
  logic [RADIUS_W-1:0] gate_lim  = GATE_RADIUS_RST;
  point3_t             stored_pts [DEPTH];
  int unsigned         stored_count = 0;

  cand_item_t    pending_points [$];
  point_result_t expected_verdicts [$];
  point3_t       point_hist [$];

  int unsigned snd_idle_pct = 24;
  int unsigned rcv_idle_pct = 65;
  logic        in_taken     = 1'b0;
  int unsigned points_taken = 0;
  int unsigned results_seen = 0;
  int unsigned reg_writes   = 0;
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned status_hist [4] = '{0, 0, 0, 0};
  int unsigned hold_left    = 0;
  logic        hold_done    = 1'b0;

  logic [RADIUS_W-1:0] dedup_plan [PHASES] =
    '{DEDUP_RADIUS_RST, 23'd256, RADIUS_MAX, 23'd0, 23'd0, 23'd12800};
  logic [RADIUS_W-1:0] gate_plan  [PHASES] =
    '{GATE_RADIUS_RST, 23'd2000, RADIUS_MAX, 23'd0, 23'd0, 23'd30000};

  function automatic int as_int(logic [COORD_BITS-1:0] v);
    return int'(coord_t'(v));
  endfunction

  function automatic longint dist_sq(point3_t a, point3_t b);
    longint acc;
    longint dd;
    acc = 0;
    for (int k = 0; k < 3; k++) begin
      dd = longint'(coord_t'(a[k])) - longint'(coord_t'(b[k]));
      acc += dd * dd;
    end
    return acc;
  endfunction

  // Gate test against the observer, then first-match scan from entry 0, then append
  function automatic point_result_t classify_point(cand_item_t it);
    point_result_t r;
    longint        lim;
    logic          found;
    r     = '0;
    found = 1'b0;
    if (dist_sq(it.cand, it.obs) > longint'(gate_lim) * longint'(gate_lim)) begin
      r.status = STATUS_BEYOND;
    end else begin
      lim = longint'(dedup_lim) * longint'(dedup_lim);
      for (int i = 0; i < stored_count; i++) begin
        if (dist_sq(stored_pts[i], it.cand) < lim) begin
          found         = 1'b1;
          r.entry_index = INDEX_OUT_W'(i);
          break;
        end
      end
      if (found) begin
        r.status = STATUS_DUP;
      end else if (stored_count < DEPTH) begin
        r.status                 = STATUS_NEW;
        r.entry_index            = INDEX_OUT_W'(stored_count);
        stored_pts[stored_count] = it.cand;
        stored_count++;
      end else begin
        r.status = STATUS_FULL;
      end
    end
    r.point_count = COUNT_OUT_W'(stored_count);
    return r;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_DEDUP_RADIUS: dedup_lim = data[RADIUS_W-1:0];
      CFG_GATE_RADIUS:  gate_lim  = data[RADIUS_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endfunction

  function automatic void note_error(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] ERROR: %s", $realtime, msg);
  endfunction

  function automatic void check_verdict(point_result_t got);
    point_result_t want;
    status_hist[got.status]++;
    if (expected_verdicts.size() == 0) begin
      note_error($sformatf("unexpected result: status %0d index %0d count %0d",
                           got.status, got.entry_index, got.point_count));
      return;
    end
    want = expected_verdicts.pop_front();
    if (got.status !== want.status || got.entry_index !== want.entry_index ||
        got.point_count !== want.point_count) begin
      note_error($sformatf("result %0d: expected status %0d index %0d count %0d, got %0d %0d %0d",
                           results_seen, want.status, want.entry_index, want.point_count,
                           got.status, got.entry_index, got.point_count));
    end
  endfunction

  function automatic point3_t pt(int x, int y, int z);
    return {COORD_BITS'(z), COORD_BITS'(y), COORD_BITS'(x)};
  endfunction

  function automatic logic [COORD_BITS-1:0] jitter(logic [COORD_BITS-1:0] base, int spread);
    return COORD_BITS'(as_int(base) + int'($urandom_range(2 * spread)) - spread);
  endfunction

  function automatic void queue_point(point3_t c, point3_t o);
    pending_points.insert(pending_points.size(), {o, c});
    point_hist.insert(point_hist.size(), c);
  endfunction

  // Random item: often near earlier points inside the gate, plus boundaries and noise
  function automatic void queue_random_point();
    point3_t c;
    point3_t o;
    point3_t hp;
    int      d;
    int      g;
    int      sel;
    int      sub;
    int      k;
    int      off;
    d   = int'(dedup_lim);
    g   = int'(gate_lim);
    sel = $urandom_range(99);
    sub = $urandom_range(3);
    k   = $urandom_range(2);
    for (int a = 0; a < 3; a++) begin
      c[a] = COORD_BITS'($urandom);
      o[a] = COORD_BITS'($urandom);
    end
    if (sel < 44 && point_hist.size() != 0) begin
      // near an earlier candidate, some just outside the dedup radius
      hp = point_hist[$urandom_range(point_hist.size() - 1)];
      for (int a = 0; a < 3; a++) c[a] = jitter(hp[a], d * 2 / 3);
      for (int a = 0; a < 3; a++) o[a] = jitter(c[a], g / 2);
    end else if (sel < 48) begin
      // fresh point inside the gate
      for (int a = 0; a < 3; a++) o[a] = jitter(c[a], g / 2);
    end else if (sel < 66) begin
      // beyond the gate along one axis
      o      = c;
      off    = g + 1 + int'($urandom_range(g));
      o[k]   = COORD_BITS'(as_int(c[k]) + ($urandom_range(1) ? off : -off));
    end else if (sel < 78) begin
      if (sub < 2 || point_hist.size() == 0) begin
        // exactly on the gate radius, or one step past it
        o    = c;
        off  = g + (sub & 1);
        o[k] = COORD_BITS'(as_int(c[k]) + ($urandom_range(1) ? off : -off));
      end else begin
        // exactly on the dedup radius of an earlier point, or one step inside
        hp   = point_hist[$urandom_range(point_hist.size() - 1)];
        c    = hp;
        off  = d - (sub - 2);
        c[k] = COORD_BITS'(as_int(hp[k]) + ($urandom_range(1) ? off : -off));
        o    = c;
      end
    end
    queue_point(c, o);
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Radius word with random bits above the radius field
  function automatic logic [CFG_DATA_W-1:0] radius_word(logic [RADIUS_W-1:0] r);
    return {(CFG_DATA_W - RADIUS_W)'($urandom), r};
  endfunction

  task automatic wait_drained();
    while (pending_points.size() != 0 || s_axis_tvalid || expected_verdicts.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Input driver: next item once the current one is taken, with random gaps
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      if (pending_points.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
        s_axis_tdata  <= IN_TDATA_W'(pending_points.pop_front());
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls plus one long hold-off
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_done     <= 1'b1;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Monitor: predict on accept, check on result, apply register writes, watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_verdicts.insert(expected_verdicts.size(),
                                 classify_point(cand_item_t'(s_axis_tdata)));
        points_taken++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        check_verdict(point_result_t'(m_axis_tdata));
        results_seen++;
      end
      if (cfg_valid_i && cfg_ready_o) apply_reg(cfg_index_i, cfg_data_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("[%0t] watchdog: no handshake for %0d cycles, %0d results pending",
                   $realtime, quiet_cycles, expected_verdicts.size());
          $display("*** FAILED ***");
          $finish;
        end
      end
    end
  end

  // Stimulus
  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Default radii: empty table, repeat, gate edge, dedup edge, first match, extremes
    queue_point(pt(0, 0, 0), pt(0, 0, 0));
    queue_point(pt(0, 0, 0), pt(0, 0, 0));
    queue_point(pt(100000, 0, 0), pt(92320, 0, 0));
    queue_point(pt(100000, 0, 0), pt(92319, 0, 0));
    queue_point(pt(0, 25600, 0), pt(0, 25600, 0));
    queue_point(pt(0, 12800, 0), pt(0, 12800, 0));
    queue_point(pt(0, 0, 25599), pt(0, 0, 25599));
    queue_point(pt(COORD_MIN, COORD_MIN, COORD_MIN), pt(COORD_MAX, COORD_MAX, COORD_MAX));
    queue_point(pt(COORD_MAX, COORD_MAX, COORD_MAX), pt(COORD_MAX, COORD_MAX, COORD_MAX));
    queue_point(pt(COORD_MIN, COORD_MIN, COORD_MIN), pt(COORD_MIN, COORD_MIN, COORD_MIN));
    wait_drained();

    // Largest radii
    write_reg(CFG_DEDUP_RADIUS, radius_word(RADIUS_MAX));
    write_reg(CFG_GATE_RADIUS, radius_word(RADIUS_MAX));
    queue_point(pt(COORD_MAX, COORD_MAX, COORD_MAX), pt(COORD_MIN, COORD_MIN, COORD_MIN));
    queue_point(pt(int'(RADIUS_MAX), 0, 0), pt(0, 0, 0));
    queue_point(pt(-100, 5, 7), pt(-100, 5, 7));
    wait_drained();

    // Zero radii: only an exact observer hit passes, nothing ever matches
    write_reg(CFG_DEDUP_RADIUS, radius_word('0));
    write_reg(CFG_GATE_RADIUS, radius_word('0));
    queue_point(pt(0, 0, 0), pt(0, 0, 0));
    queue_point(pt(1, 0, 0), pt(0, 0, 0));
    queue_point(pt(0, 0, 0), pt(0, 0, 0));
    wait_drained();

    // Undecoded indexes must leave the radii alone
    write_reg(CFG_SPARE_2, $urandom);
    write_reg(CFG_SPARE_3, $urandom);
    queue_point(pt(5, 5, 5), pt(5, 5, 5));
    queue_point(pt(5, 5, 6), pt(5, 5, 5));

    // Random phases, each under its own radius setting
    dedup_plan[3] = RADIUS_W'($urandom_range(100000));
    gate_plan[3]  = RADIUS_W'($urandom_range(200000));
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      if (ph == 2) begin
        snd_idle_pct = 65;
        rcv_idle_pct = 24;
      end else if (ph == 4) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      write_reg(CFG_DEDUP_RADIUS, radius_word(dedup_plan[ph]));
      write_reg(CFG_GATE_RADIUS, radius_word(gate_plan[ph]));
      if (ph == 3) write_reg($urandom_range(1) ? CFG_SPARE_2 : CFG_SPARE_3, $urandom);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // sender pauses until every pending result is back
        if (ph == 1 && n == ITEMS_PER_PHASE / 2) wait_drained();
        queue_random_point();
      end
    end

    wait_drained();
    $display("covered %0d points: %0d beyond gate, %0d duplicates, %0d stored, %0d table full",
             points_taken, status_hist[STATUS_BEYOND], status_hist[STATUS_DUP],
             status_hist[STATUS_NEW], status_hist[STATUS_FULL]);
    $display("%0d register writes across %0d radius settings, %0d mismatches",
             reg_writes, PHASES + 3, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- proximity_dedup_point_table_unit.f -----
hw/rtl/pdpt_pkg.sv
hw/rtl/pdpt_ram.sv
hw/rtl/pdpt_datapath.sv
hw/rtl/pdpt_ctrl.sv
hw/rtl/proximity_dedup_point_table_unit.sv
tb/sv/testbench.sv
